>>> rtl/serial_frame_receiver_dispatch_top_assert.svh
// Assertion macros for the frame receiver
`ifndef SERIAL_FRAME_RECEIVER_DISPATCH_TOP_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_DISPATCH_TOP_ASSERT_SVH

// same-cycle implication
`define SFRD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame receiver assertion failed");

// next-cycle implication
`define SFRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver assertion failed");

`endif

>>> rtl/sfrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sfrd_pkg;

  localparam int unsigned HDR_LEN     = 5;
  localparam int unsigned STAGE_DEPTH = 16;
  localparam int unsigned ROW_BYTES   = 15;
  localparam int unsigned ROW_COUNT   = 4;
  localparam int unsigned ROW_W       = ROW_BYTES * 8;

  localparam logic [7:0] SYNC_VAL = 8'hFC;
  localparam logic [7:0] PRE_A    = 8'h02;
  localparam logic [7:0] PRE_B    = 8'h7A;

  localparam logic [7:0] T_SET_REQ = 8'h41;
  localparam logic [7:0] T_SET_RSP = 8'h61;
  localparam logic [7:0] T_GET_REQ = 8'h42;
  localparam logic [7:0] T_GET_RSP = 8'h62;
  localparam logic [7:0] T_CON_REQ = 8'h5A;
  localparam logic [7:0] T_CON_RSP = 8'h7A;
  localparam logic [7:0] T_EXC_REQ = 8'h5B;
  localparam logic [7:0] T_EXC_RSP = 8'h7B;

  localparam logic [7:0] CODE_SET_FIRST = 8'h32;
  localparam logic [7:0] CODE_SET_LAST  = 8'h35;
  localparam logic [7:0] CODE_HEARTBEAT = 8'h34;
  localparam logic [7:0] CODE_EXT_CON   = 8'hC9;
  localparam logic [7:0] FLAG_ON        = 8'h01;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_REPLY     = 4'd1;
  localparam logic [3:0] EV_CONNECT   = 4'd2;
  localparam logic [3:0] EV_WRITE_ACK = 4'd3;
  localparam logic [3:0] EV_HEARTBEAT = 4'd4;
  localparam logic [3:0] EV_SYNC_ONE  = 4'd5;
  localparam logic [3:0] EV_SYNC_TWO  = 4'd6;
  localparam logic [3:0] EV_NO_ACTION = 4'd7;
  localparam logic [3:0] EV_READBACK  = 4'd8;

  localparam int unsigned PAT_ONE_LEN = 8;
  localparam int unsigned PAT_TWO_LEN = 9;
  localparam logic [7:0] PAT_ONE [PAT_ONE_LEN] = '{
    8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02
  };
  localparam logic [7:0] PAT_TWO [PAT_TWO_LEN] = '{
    8'h02, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] packet_type;
    logic [7:0] active_message;
    logic       heartbeat_on;
    logic [7:0] read_data;
  } res_t;

  function automatic logic type_known(input logic [7:0] t);
    return t inside {T_SET_REQ, T_SET_RSP, T_GET_REQ, T_GET_RSP,
                     T_CON_REQ, T_CON_RSP, T_EXC_REQ, T_EXC_RSP};
  endfunction

  function automatic logic get_code_known(input logic [7:0] c);
    return c inside {[8'h01:8'h07], 8'h09, [8'h0B:8'h11], [8'h13:8'h20],
                     [8'h26:8'h29], [8'hA1:8'hA3]};
  endfunction

endpackage
`default_nettype wire

>>> rtl/sfrd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sfrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/serial_frame_receiver_dispatch_top.sv
// Serial frame receiver with event dispatch.
// Input channel (in_valid_i / in_stall_o): one beat is either a received byte
// (opcode 0, rx_byte_i) or a readback of a stored setting byte (opcode 1,
// setting_slot_i, setting_index_i). Every input beat yields exactly one output
// beat (out_valid_o / out_stall_i side) carrying the event and its fields.
// The result of an accepted beat is registered in the pipeline stage, then
// written into the output queue. Throughput: one beat per cycle, sustained
// while the receiver does not stall; the registered read of the settings
// memory sets the pipeline stage between input and queue.
// Settings live in a 4-row RAM, one row of 15 bytes per set code, written
// when a set frame is accepted; a per-row valid flag makes unwritten
// rows read as zero, so no clearing pass is needed.
// Reset: all frame and matcher state returns to zero, the output queue empties
// and every setting reads as zero.
// Stall: results wait in a two-entry output queue; the input keeps taking
// beats until the pipeline stage and that queue hold two results besides any
// the receiver is taking, then in_stall_o rises until the receiver takes one.
`timescale 1ns / 1ps
`default_nettype none
module serial_frame_receiver_dispatch_top
  import sfrd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       opcode_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [1:0] setting_slot_i,
  input  wire logic [3:0] setting_index_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [3:0]      event_res_o,
  output logic [7:0]      packet_type_o,
  output logic [7:0]      active_message_o,
  output logic            heartbeat_on_o,
  output logic [7:0]      read_data_o
);

  localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned POS_W  = $clog2(HDR_LEN + MAX_PAYLOAD + 1);
  localparam int unsigned ROW_AW = $clog2(ROW_COUNT);

  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       ftype_q, ftype_d;
  logic [7:0]       stage_q [STAGE_DEPTH];
  logic [7:0]       stage_d [STAGE_DEPTH];
  logic [7:0]       commit_q [STAGE_DEPTH];
  logic [7:0]       commit_d [STAGE_DEPTH];
  logic [3:0]       sp1_q, sp1_d;
  logic [3:0]       sp2_q, sp2_d;
  logic [ROW_COUNT-1:0] row_valid_q, row_valid_d;

  logic              frame_done;
  logic              hdr_ok;
  logic              sync1_fire;
  logic [POS_W-1:0]  k;
  logic [7:0]        code;
  res_t              res;
  logic              store;
  logic [ROW_AW-1:0] waddr;
  logic [ROW_W-1:0]  wdata;

  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    sum_d       = sum_q;
    ftype_d     = ftype_q;
    stage_d     = stage_q;
    commit_d    = commit_q;
    sp1_d       = sp1_q;
    sp2_d       = sp2_q;
    frame_done  = 1'b0;
    hdr_ok      = 1'b1;
    sync1_fire  = 1'b0;
    k           = pos_q - POS_W'(HDR_LEN);
    if (accept && opcode_i == OP_PUSH) begin
      if (pos_q < POS_W'(HDR_LEN)) begin
        if (pos_q == '0) begin
          if (rx_byte_i == SYNC_VAL) begin
            sum_d = rx_byte_i;
            pos_d = POS_W'(1);
          end
        end else begin
          case (pos_q[2:0])
            3'd1: begin
              hdr_ok  = type_known(rx_byte_i);
              ftype_d = rx_byte_i;
            end
            3'd2: hdr_ok = (rx_byte_i == PRE_A);
            3'd3: hdr_ok = (rx_byte_i == PRE_B);
            default: begin
              hdr_ok = (rx_byte_i <= 8'(MAX_PAYLOAD));
              if (hdr_ok) begin
                len_d = rx_byte_i[LEN_W-1:0];
              end
            end
          endcase
          if (hdr_ok) begin
            sum_d = sum_q + rx_byte_i;
            pos_d = pos_q + POS_W'(1);
          end else begin
            pos_d = '0;
          end
        end
      end else if (pos_q < POS_W'(HDR_LEN) + POS_W'(len_q)) begin
        if (k < POS_W'(STAGE_DEPTH)) begin
          stage_d[k[3:0]] = rx_byte_i;
        end
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + POS_W'(1);
      end else begin
        pos_d      = '0;
        frame_done = ((SYNC_VAL - sum_q) == rx_byte_i);
        if (frame_done) begin
          for (int i = 0; i < STAGE_DEPTH; i++) begin
            if (LEN_W'(i) < len_q) begin
              commit_d[i] = stage_q[i];
            end
          end
        end
      end
      if (!frame_done) begin
        if (sp1_q >= 4'(PAT_ONE_LEN)) begin
          sp1_d      = '0;
          sync1_fire = 1'b1;
          for (int i = 0; i < PAT_ONE_LEN; i++) begin
            commit_d[i] = PAT_ONE[i];
          end
        end else if (rx_byte_i == PAT_ONE[sp1_q[2:0]]) begin
          sp1_d = sp1_q + 4'd1;
        end else begin
          sp1_d = '0;
        end
        if (!sync1_fire) begin
          if (sp2_q >= 4'(PAT_TWO_LEN)) begin
            sp2_d = '0;
            for (int i = 0; i < PAT_TWO_LEN; i++) begin
              commit_d[i] = PAT_TWO[i];
            end
          end else if (rx_byte_i == PAT_TWO[sp2_q]) begin
            sp2_d = sp2_q + 4'd1;
          end else begin
            sp2_d = '0;
          end
        end
      end
    end
  end

  always_comb begin
    code        = commit_d[0];
    res         = '0;
    store       = 1'b0;
    row_valid_d = row_valid_q;
    if (accept) begin
      if (opcode_i == OP_READ) begin
        res.event_res = EV_READBACK;
      end else if (frame_done) begin
        res.packet_type = ftype_q;
        res.event_res   = EV_NO_ACTION;
        case (ftype_q)
          T_GET_REQ: begin
            if (get_code_known(code)) begin
              res.event_res      = EV_REPLY;
              res.active_message = code;
            end
          end
          T_EXC_REQ: begin
            if (code == CODE_EXT_CON) begin
              res.event_res      = EV_REPLY;
              res.active_message = code;
            end
          end
          T_SET_RSP: res.event_res = EV_WRITE_ACK;
          T_SET_REQ: begin
            if (code == CODE_HEARTBEAT && commit_d[2] == FLAG_ON) begin
              res.event_res    = EV_HEARTBEAT;
              res.heartbeat_on = (commit_d[11] == FLAG_ON);
            end else if (code inside {[CODE_SET_FIRST:CODE_SET_LAST]}) begin
              store              = 1'b1;
              res.event_res      = EV_REPLY;
              res.active_message = code;
            end
          end
          T_CON_REQ: res.event_res = EV_CONNECT;
          default: res.event_res = EV_NO_ACTION;
        endcase
      end else if (sync1_fire) begin
        res.event_res = EV_SYNC_ONE;
      end else if (sp2_q >= 4'(PAT_TWO_LEN)) begin
        res.event_res = EV_SYNC_TWO;
      end
    end
    waddr = ROW_AW'(code - CODE_SET_FIRST);
    for (int i = 0; i < ROW_BYTES; i++) begin
      wdata[i*8 +: 8] = commit_d[i+1];
    end
    if (store) begin
      row_valid_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      len_q       <= '0;
      sum_q       <= '0;
      ftype_q     <= '0;
      sp1_q       <= '0;
      sp2_q       <= '0;
      row_valid_q <= '0;
      for (int i = 0; i < STAGE_DEPTH; i++) begin
        stage_q[i]  <= '0;
        commit_q[i] <= '0;
      end
    end else begin
      pos_q       <= pos_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      ftype_q     <= ftype_d;
      sp1_q       <= sp1_d;
      sp2_q       <= sp2_d;
      row_valid_q <= row_valid_d;
      stage_q     <= stage_d;
      commit_q    <= commit_d;
    end
  end

  logic [ROW_W-1:0] ram_rdata;
  logic             ram_re;
  assign ram_re = accept && opcode_i == OP_READ;

  sfrd_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROW_COUNT)
  ) u_settings (
    .clk_i  (clk_i),
    .we_i   (store),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ram_re),
    .raddr_i(setting_slot_i),
    .rdata_o(ram_rdata)
  );

  logic       s1_valid_q;
  res_t       s1_res_q;
  logic       s1_rb_q;
  logic       s1_rowv_q;
  logic [3:0] s1_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q  <= res;
      s1_rb_q   <= (opcode_i == OP_READ);
      s1_rowv_q <= row_valid_q[setting_slot_i];
      s1_idx_q  <= setting_index_i;
    end
  end

  logic [3:0] bsel;
  res_t       s2_res;

  always_comb begin
    bsel   = s1_idx_q - 4'd1;
    s2_res = s1_res_q;
    s2_res.read_data = '0;
    if (s1_rb_q && s1_rowv_q && s1_idx_q != '0) begin
      for (int b = 0; b < ROW_BYTES; b++) begin
        if (bsel == 4'(b)) begin
          s2_res.read_data = ram_rdata[b*8 +: 8];
        end
      end
    end
  end

  res_t       fifo_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;
  logic [2:0] occ;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign occ         = {1'b0, cnt_q} + {2'b00, s1_valid_q} - {2'b00, pop};
  assign in_stall_o  = (occ > 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (s1_valid_q) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, s1_valid_q} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fifo_q[wr_ptr_q] <= s2_res;
    end
  end

  res_t head;
  assign head             = fifo_q[rd_ptr_q];
  assign event_res_o      = head.event_res;
  assign packet_type_o    = head.packet_type;
  assign active_message_o = head.active_message;
  assign heartbeat_on_o   = head.heartbeat_on;
  assign read_data_o      = head.read_data;

`include "serial_frame_receiver_dispatch_top_assert.svh"

  `SFRD_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, accept, s1_valid_q)
  `SFRD_ASSERT_SAME(a_queue_has_room, clk_i, rst_ni, s1_valid_q, cnt_q < 2'd2)
  `SFRD_ASSERT_SAME(a_readback_clean, clk_i, rst_ni,
    out_valid_o && event_res_o == EV_READBACK,
    packet_type_o == '0 && active_message_o == '0)
  `SFRD_ASSERT_SAME(a_heartbeat_only, clk_i, rst_ni,
    out_valid_o && heartbeat_on_o, event_res_o == EV_HEARTBEAT)

endmodule
`default_nettype wire

>>> tb/serial_frame_receiver_dispatch_top_tb.sv
`timescale 1ns / 1ps
module serial_frame_receiver_dispatch_top_tb;
  import sfrd_pkg::*;

  localparam int MAX_PAYLOAD    = 16;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HB_FLAG_POS    = 2;
  localparam int HB_STATE_POS   = 11;
  localparam int GET_SPAN_COUNT = 6;
  localparam logic [7:0] GET_SPANS [GET_SPAN_COUNT][2] = '{
    '{8'h01, 8'h07}, '{8'h09, 8'h09}, '{8'h0B, 8'h11},
    '{8'h13, 8'h20}, '{8'h26, 8'h29}, '{8'hA1, 8'hA3}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       opcode_i = OP_PUSH;
  logic [7:0] rx_byte_i = 8'h00;
  logic [1:0] setting_slot_i = 2'd0;
  logic [3:0] setting_index_i = 4'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [3:0] event_res_o;
  logic [7:0] packet_type_o;
  logic [7:0] active_message_o;
  logic       heartbeat_on_o;
  logic [7:0] read_data_o;

  serial_frame_receiver_dispatch_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .rx_byte_i       (rx_byte_i),
    .setting_slot_i  (setting_slot_i),
    .setting_index_i (setting_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_res_o     (event_res_o),
    .packet_type_o   (packet_type_o),
    .active_message_o(active_message_o),
    .heartbeat_on_o  (heartbeat_on_o),
    .read_data_o     (read_data_o)
  );

  always #5 clk_i = ~clk_i;

  // receiver-side model of the block
  int         frm_pos = 0;
  int         pay_len = 0;
  logic [7:0] chk_sum = 8'h00;
  logic [7:0] frm_type = 8'h00;
  logic [7:0] stage_buf [STAGE_DEPTH] = '{default: 8'h00};
  logic [7:0] commit_buf [STAGE_DEPTH] = '{default: 8'h00};
  int         sync1_pos = 0;
  int         sync2_pos = 0;
  logic [7:0] settings_mem [ROW_COUNT * ROW_BYTES] = '{default: 8'h00};

  res_t       expected_events [$];
  int         mismatch_count = 0;
  int         beats_sent = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         stall_hold = 0;
  logic [7:0] payload_buf [MAX_PAYLOAD];

  function automatic bit get_code_ok(input logic [7:0] c);
    for (int s = 0; s < GET_SPAN_COUNT; s++) begin
      if (c >= GET_SPANS[s][0] && c <= GET_SPANS[s][1]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit frame_step(input logic [7:0] c);
    bit ok;
    int p;
    p = frm_pos;
    ok = 1'b1;
    if (p < HDR_LEN) begin
      case (p)
        0: begin
          if (c != SYNC_VAL) return 1'b0;
          chk_sum = 8'h00;
        end
        1: begin
          frm_type = c;
          case (c)
            T_SET_REQ, T_SET_RSP, T_GET_REQ, T_GET_RSP,
            T_CON_REQ, T_CON_RSP, T_EXC_REQ, T_EXC_RSP: ok = 1'b1;
            default: ok = 1'b0;
          endcase
        end
        2: ok = (c == PRE_A);
        3: ok = (c == PRE_B);
        default: begin
          ok = (c <= MAX_PAYLOAD);
          if (ok) pay_len = c;
        end
      endcase
      if (!ok) begin
        frm_pos = 0;
        return 1'b0;
      end
      chk_sum = chk_sum + c;
      frm_pos = p + 1;
      return 1'b0;
    end
    if (p < HDR_LEN + pay_len) begin
      if (p - HDR_LEN < STAGE_DEPTH) stage_buf[p - HDR_LEN] = c;
      chk_sum = chk_sum + c;
      frm_pos = p + 1;
      return 1'b0;
    end
    frm_pos = 0;
    if (8'(SYNC_VAL - chk_sum) != c) return 1'b0;
    for (int i = 0; i < STAGE_DEPTH; i++) begin
      if (i < pay_len) commit_buf[i] = stage_buf[i];
    end
    return 1'b1;
  endfunction

  function automatic bit sync_step(input bit second, input logic [7:0] c);
    int pos;
    int len;
    logic [7:0] want;
    bit fired;
    fired = 1'b0;
    if (second) begin
      pos = sync2_pos;
      len = PAT_TWO_LEN;
    end else begin
      pos = sync1_pos;
      len = PAT_ONE_LEN;
    end
    if (pos >= len) begin
      for (int i = 0; i < len; i++) begin
        if (second) commit_buf[i] = PAT_TWO[i];
        else commit_buf[i] = PAT_ONE[i];
      end
      pos = 0;
      fired = 1'b1;
    end else begin
      if (second) want = PAT_TWO[pos];
      else want = PAT_ONE[pos];
      pos = (c == want) ? pos + 1 : 0;
    end
    if (second) sync2_pos = pos;
    else sync1_pos = pos;
    return fired;
  endfunction

  function automatic res_t predict_event(input logic op, input logic [7:0] c,
                                         input logic [1:0] slot, input logic [3:0] idx);
    res_t r;
    logic [7:0] code;
    int base;
    r = '0;
    if (op == OP_READ) begin
      r.event_res = EV_READBACK;
      if (idx != 4'd0) r.read_data = settings_mem[int'(slot) * ROW_BYTES + int'(idx) - 1];
      return r;
    end
    if (frame_step(c)) begin
      code = commit_buf[0];
      r.packet_type = frm_type;
      r.event_res = EV_NO_ACTION;
      case (frm_type)
        T_GET_REQ: if (get_code_ok(code)) begin
          r.event_res = EV_REPLY;
          r.active_message = code;
        end
        T_EXC_REQ: if (code == CODE_EXT_CON) begin
          r.event_res = EV_REPLY;
          r.active_message = code;
        end
        T_SET_RSP: r.event_res = EV_WRITE_ACK;
        T_SET_REQ: begin
          if (code == CODE_HEARTBEAT && commit_buf[HB_FLAG_POS] == FLAG_ON) begin
            r.event_res = EV_HEARTBEAT;
            r.heartbeat_on = (commit_buf[HB_STATE_POS] == FLAG_ON);
          end else if (code >= CODE_SET_FIRST && code <= CODE_SET_LAST) begin
            base = int'(code - CODE_SET_FIRST) * ROW_BYTES;
            for (int i = 0; i < ROW_BYTES; i++) settings_mem[base + i] = commit_buf[i + 1];
            r.event_res = EV_REPLY;
            r.active_message = code;
          end
        end
        T_CON_REQ: r.event_res = EV_CONNECT;
        default: ;
      endcase
    end else if (sync_step(1'b0, c)) begin
      r.event_res = EV_SYNC_ONE;
    end else if (sync_step(1'b1, c)) begin
      r.event_res = EV_SYNC_TWO;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input res_t want, input res_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t %s", $time, what);
      $display("  expected ev=%0d type=%h msg=%h hb=%b rd=%h", want.event_res,
               want.packet_type, want.active_message, want.heartbeat_on, want.read_data);
      $display("  actual   ev=%0d type=%h msg=%h hb=%b rd=%h", got.event_res,
               got.packet_type, got.active_message, got.heartbeat_on, got.read_data);
    end
  endtask

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_events.push_back(predict_event(opcode_i, rx_byte_i, setting_slot_i,
                                                setting_index_i));
      end
      if (out_valid_o && !out_stall_i) begin
        got = {event_res_o, packet_type_o, active_message_o, heartbeat_on_o, read_data_o};
        if (expected_events.size() == 0) begin
          report_mismatch("result beat with nothing expected", '0, got);
        end else begin
          want = expected_events.pop_front();
          if (got.event_res !== want.event_res || got.packet_type !== want.packet_type ||
              got.active_message !== want.active_message ||
              got.heartbeat_on !== want.heartbeat_on || got.read_data !== want.read_data) begin
            report_mismatch("result beat mismatch", want, got);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      out_stall_i <= 1'b1;
      stall_hold--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] c,
                           input logic [1:0] slot, input logic [3:0] idx);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    rx_byte_i <= c;
    setting_slot_i <= slot;
    setting_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic push_byte(input logic [7:0] c);
    send_beat(OP_PUSH, c, 2'($urandom), 4'($urandom));
  endtask

  task automatic read_setting(input logic [1:0] slot, input logic [3:0] idx);
    send_beat(OP_READ, 8'($urandom), slot, idx);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] ptype, input int len, input bit spoil);
    logic [7:0] sum;
    sum = SYNC_VAL + ptype + PRE_A + PRE_B + 8'(len);
    push_byte(SYNC_VAL);
    push_byte(ptype);
    push_byte(PRE_A);
    push_byte(PRE_B);
    push_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      push_byte(payload_buf[i]);
      sum = sum + payload_buf[i];
    end
    push_byte(8'(SYNC_VAL - sum) + (spoil ? 8'($urandom_range(1, 255)) : 8'h00));
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 9))
      0, 8:    return T_SET_REQ;
      1:       return T_SET_RSP;
      2, 9:    return T_GET_REQ;
      3:       return T_GET_RSP;
      4:       return T_CON_REQ;
      5:       return T_CON_RSP;
      6:       return T_EXC_REQ;
      default: return T_EXC_RSP;
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    int s;
    s = $urandom_range(0, GET_SPAN_COUNT - 1);
    case ($urandom_range(0, 6))
      0, 1:    return 8'($urandom_range(GET_SPANS[s][0], GET_SPANS[s][1]));
      2:       return ($urandom_range(0, 1)) ? 8'(GET_SPANS[s][0] - 1) : 8'(GET_SPANS[s][1] + 1);
      3:       return 8'(CODE_SET_FIRST + $urandom_range(0, 3));
      4:       return CODE_HEARTBEAT;
      5:       return CODE_EXT_CON;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_traffic(input int count);
    int stop_at;
    int kind;
    int len;
    int cut;
    bit second;
    logic [7:0] pat_byte;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(0, MAX_PAYLOAD);
        payload_buf[0] = pick_code();
        for (int i = 1; i < MAX_PAYLOAD; i++) payload_buf[i] = 8'($urandom);
        if ($urandom_range(0, 1)) payload_buf[HB_FLAG_POS] = FLAG_ON;
        if ($urandom_range(0, 1)) payload_buf[HB_STATE_POS] = FLAG_ON;
        send_frame(pick_type(), len, $urandom_range(0, 9) == 0);
      end else if (kind < 65) begin
        // break the header at one position
        cut = $urandom_range(1, 4);
        push_byte(SYNC_VAL);
        if (cut == 1) begin
          push_byte(8'($urandom_range(0, T_SET_REQ - 1)));
        end else begin
          push_byte(pick_type());
          if (cut == 2) begin
            push_byte(8'(PRE_A + $urandom_range(1, 255)));
          end else begin
            push_byte(PRE_A);
            if (cut == 3) begin
              push_byte(PRE_B ^ 8'(1 << $urandom_range(0, 7)));
            end else begin
              push_byte(PRE_B);
              push_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end
          end
        end
      end else if (kind < 77) begin
        second = $urandom_range(0, 1);
        len = second ? PAT_TWO_LEN : PAT_ONE_LEN;
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < len; i++) begin
          if (second) pat_byte = PAT_TWO[i];
          else pat_byte = PAT_ONE[i];
          push_byte((i == cut) ? ~pat_byte : pat_byte);
        end
        if (cut == len) push_byte(8'($urandom));
      end else if (kind < 90) begin
        read_setting(2'($urandom), 4'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_byte(($urandom_range(0, 3) == 0) ? SYNC_VAL : 8'($urandom));
        end
      end
    end
  endtask

  task automatic test_readback_extremes();
    read_setting(2'd3, 4'd15);
    read_setting(2'd0, 4'd0);
  endtask

  task automatic test_header_mismatch();
    push_byte(SYNC_VAL);
    push_byte(8'h00);
    push_byte(SYNC_VAL);
    push_byte(SYNC_VAL);
  endtask

  task automatic test_bad_checksum();
    send_frame(T_CON_REQ, 0, 1'b1);
  endtask

  task automatic test_connect_frame();
    send_frame(T_CON_REQ, 0, 1'b0);
  endtask

  task automatic test_sync_pattern();
    for (int i = 0; i < PAT_ONE_LEN; i++) push_byte(PAT_ONE[i]);
    push_byte(8'hFF);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    random_traffic(count);
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_hold = 60;
    random_traffic(40);
    wait_drained();
  endtask

  initial begin
    #5_000_000;
    $display("serial_frame_receiver_dispatch_top_tb failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 33;
    recv_idle_pct = 63;
    test_readback_extremes();
    test_header_mismatch();
    test_bad_checksum();
    test_connect_frame();
    test_sync_pattern();
    wait_drained();
    test_random_traffic(33, 63, 500);
    test_output_hold_off();
    test_random_traffic(63, 33, 500);
    test_random_traffic(0, 0, 480);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("serial_frame_receiver_dispatch_top_tb passed");
    end else begin
      $display("serial_frame_receiver_dispatch_top_tb failed");
    end
    $finish;
  end

endmodule
